/* rtl/fgpq_pkg.sv */
`timescale 1ns / 1ps

package fgpq_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int FRAME_BYTES = 32;

    // request op codes
    localparam logic [2:0] OP_FRAME_START = 3'd0;
    localparam logic [2:0] OP_FRAME_END   = 3'd1;
    localparam logic [2:0] OP_LINE_BYTE   = 3'd2;
    localparam logic [2:0] OP_HOST_WRITE  = 3'd3;
    localparam logic [2:0] OP_HOST_READ   = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_TX     = 2'd1;
    localparam logic [1:0] KIND_RX     = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_LONG  = 2'd3;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic       last;
    } t_req;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       end_of_run;
        logic [1:0] status;
        logic       bus_active;
        logic [2:0] rx_count;
        logic [2:0] tx_count;
    } t_res;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic emit_next;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic start_multi;
        logic step_more;
    } t_sts;

endpackage

/* rtl/fgpq_ctrl.sv */
`timescale 1ns / 1ps

module fgpq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    output fgpq_pkg::t_ctl  o_ctl,
    input  fgpq_pkg::t_sts  i_sts
);

    fgpq_pkg::t_state r_state;
    fgpq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fgpq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        busy    = 1'b0;
        o_ctl   = '0;
        unique case (r_state)
            fgpq_pkg::S_IDLE: begin
                o_ctl.accept = start;
                // packet longer than one byte keeps the block busy
                if (start && i_sts.start_multi) begin
                    n_state = fgpq_pkg::S_EMIT;
                end
            end
            fgpq_pkg::S_EMIT: begin
                busy            = 1'b1;
                o_ctl.emit_next = 1'b1;
                if (!i_sts.step_more) begin
                    n_state = fgpq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fgpq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/fgpq_dp.sv */
`timescale 1ns / 1ps

module fgpq_dp #(
    parameter int QUEUE_DEPTH = fgpq_pkg::QUEUE_DEPTH,
    parameter int FRAME_BYTES = fgpq_pkg::FRAME_BYTES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fgpq_pkg::t_ctl  i_ctl,
    output fgpq_pkg::t_sts  o_sts,
    input  fgpq_pkg::t_req  i_req,
    output logic            o_strobe,
    output fgpq_pkg::t_res  o_res
);

    localparam int SW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW    = $clog2(QUEUE_DEPTH + 1);
    localparam int LW    = $clog2(FRAME_BYTES + 1);
    localparam int DEPTH = QUEUE_DEPTH * FRAME_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [SW-1:0] LAST_SLOT = SW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(QUEUE_DEPTH);
    localparam logic [LW-1:0] MAX_LEN   = LW'(FRAME_BYTES);

    function automatic logic [SW-1:0] f_next(input logic [SW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [SW-1:0] s, input logic [LW-1:0] p);
        return AW'(int'(s) * FRAME_BYTES + int'(p));
    endfunction

    // stores and length tables
    logic [7:0]    r_rx_mem [DEPTH];
    logic [7:0]    r_tx_mem [DEPTH];
    logic [LW-1:0] r_rx_len [QUEUE_DEPTH];
    logic [LW-1:0] r_tx_len [QUEUE_DEPTH];
    logic [7:0]    r_rx_rd;
    logic [7:0]    r_tx_rd;

    // queue control
    logic          r_active,    n_active;
    logic [SW-1:0] r_rx_head,   n_rx_head;
    logic [SW-1:0] r_rx_tail,   n_rx_tail;
    logic [FW-1:0] r_rx_fill,   n_rx_fill;
    logic [LW-1:0] r_frame_len, n_frame_len;
    logic          r_frame_ovf, n_frame_ovf;
    logic [SW-1:0] r_tx_head,   n_tx_head;
    logic [SW-1:0] r_tx_tail,   n_tx_tail;
    logic [FW-1:0] r_tx_fill,   n_tx_fill;
    logic [LW-1:0] r_write_pos, n_write_pos;
    logic          r_write_ovf, n_write_ovf;
    logic          r_out_vld,   n_out_vld;

    // emission and result payload
    logic [1:0]    r_em_kind,    n_em_kind;
    logic [SW-1:0] r_em_slot,    n_em_slot;
    logic [LW-1:0] r_em_len,     n_em_len;
    logic [LW-1:0] r_em_idx,     n_em_idx;
    logic [1:0]    r_out_kind,   n_out_kind;
    logic          r_out_bvalid, n_out_bvalid;
    logic          r_out_eor,    n_out_eor;
    logic [1:0]    r_out_status, n_out_status;

    // memory port controls
    logic          rx_we, tx_we, rx_re, tx_re;
    logic [AW-1:0] rx_wa, tx_wa, rx_ra, tx_ra;
    logic          rx_len_we, tx_len_we;
    logic [LW-1:0] tx_len_wd;

    logic [LW-1:0] rx_head_len, tx_head_len;
    logic          rx_full, tx_full, rx_any, tx_any;
    logic          step_more;
    logic [FW+2:0] rx_cnt_ext, tx_cnt_ext;

    assign rx_head_len = r_rx_len[r_rx_head];
    assign tx_head_len = r_tx_len[r_tx_head];
    assign rx_full     = (r_rx_fill == FULL_FILL);
    assign tx_full     = (r_tx_fill == FULL_FILL);
    assign rx_any      = (r_rx_fill != '0);
    assign tx_any      = (r_tx_fill != '0);
    assign step_more   = ({1'b0, r_em_idx} + 1'b1) < {1'b0, r_em_len};

    assign o_sts.step_more   = step_more;
    assign o_sts.start_multi =
        ((i_req.op == fgpq_pkg::OP_FRAME_START) && tx_any && (tx_head_len > LW'(1))) ||
        ((i_req.op == fgpq_pkg::OP_HOST_READ)   && rx_any && (rx_head_len > LW'(1)));

    always_comb begin
        logic [LW-1:0] v_pos;
        logic          v_ovf;

        n_active     = r_active;
        n_rx_head    = r_rx_head;
        n_rx_tail    = r_rx_tail;
        n_rx_fill    = r_rx_fill;
        n_frame_len  = r_frame_len;
        n_frame_ovf  = r_frame_ovf;
        n_tx_head    = r_tx_head;
        n_tx_tail    = r_tx_tail;
        n_tx_fill    = r_tx_fill;
        n_write_pos  = r_write_pos;
        n_write_ovf  = r_write_ovf;
        n_out_vld    = 1'b0;
        n_em_kind    = r_em_kind;
        n_em_slot    = r_em_slot;
        n_em_len     = r_em_len;
        n_em_idx     = r_em_idx;
        n_out_kind   = r_out_kind;
        n_out_bvalid = r_out_bvalid;
        n_out_eor    = r_out_eor;
        n_out_status = r_out_status;
        rx_we        = 1'b0;
        tx_we        = 1'b0;
        rx_re        = 1'b0;
        tx_re        = 1'b0;
        rx_wa        = f_addr(r_rx_tail, r_frame_len);
        tx_wa        = f_addr(r_tx_tail, r_write_pos);
        rx_ra        = f_addr(r_em_slot, r_em_idx);
        tx_ra        = f_addr(r_em_slot, r_em_idx);
        rx_len_we    = 1'b0;
        tx_len_we    = 1'b0;
        v_pos        = r_write_pos;
        v_ovf        = r_write_ovf;
        tx_len_wd    = r_write_pos;

        if (i_ctl.accept) begin
            n_out_vld    = 1'b1;
            n_out_kind   = fgpq_pkg::KIND_STATUS;
            n_out_bvalid = 1'b0;
            n_out_eor    = 1'b1;
            n_out_status = fgpq_pkg::ST_OK;
            unique case (i_req.op)
                fgpq_pkg::OP_FRAME_START: begin
                    n_active    = 1'b1;
                    n_frame_len = '0;
                    n_frame_ovf = 1'b0;
                    if (tx_any) begin
                        n_out_kind   = fgpq_pkg::KIND_TX;
                        n_out_bvalid = (tx_head_len != '0);
                        n_out_eor    = (tx_head_len <= LW'(1));
                        n_em_kind    = fgpq_pkg::KIND_TX;
                        n_em_slot    = r_tx_head;
                        n_em_len     = tx_head_len;
                        n_em_idx     = LW'(1);
                        tx_re        = 1'b1;
                        tx_ra        = f_addr(r_tx_head, '0);
                        n_tx_head    = f_next(r_tx_head);
                        n_tx_fill    = r_tx_fill - 1'b1;
                    end else begin
                        n_out_status = fgpq_pkg::ST_EMPTY;
                    end
                end
                fgpq_pkg::OP_FRAME_END: begin
                    n_active = 1'b0;
                    if (rx_full) begin
                        n_out_status = fgpq_pkg::ST_FULL;
                    end else if (r_frame_ovf) begin
                        n_out_status = fgpq_pkg::ST_LONG;
                    end else begin
                        rx_len_we = 1'b1;
                        n_rx_tail = f_next(r_rx_tail);
                        n_rx_fill = r_rx_fill + 1'b1;
                    end
                    n_frame_len = '0;
                    n_frame_ovf = 1'b0;
                end
                fgpq_pkg::OP_LINE_BYTE: begin
                    if (rx_full) begin
                        n_frame_ovf  = 1'b1;
                        n_out_status = fgpq_pkg::ST_FULL;
                    end else if (r_frame_len >= MAX_LEN) begin
                        n_frame_ovf  = 1'b1;
                        n_out_status = fgpq_pkg::ST_LONG;
                    end else begin
                        rx_we       = 1'b1;
                        n_frame_len = r_frame_len + 1'b1;
                    end
                end
                fgpq_pkg::OP_HOST_WRITE: begin
                    if (tx_full) begin
                        v_ovf        = 1'b1;
                        n_out_status = fgpq_pkg::ST_FULL;
                    end else if (r_write_pos >= MAX_LEN) begin
                        v_ovf        = 1'b1;
                        n_out_status = fgpq_pkg::ST_LONG;
                    end else begin
                        tx_we = 1'b1;
                        v_pos = r_write_pos + 1'b1;
                    end
                    n_write_pos = v_pos;
                    n_write_ovf = v_ovf;
                    if (i_req.last) begin
                        if (tx_full) begin
                            n_out_status = fgpq_pkg::ST_FULL;
                        end else if (v_ovf) begin
                            n_out_status = fgpq_pkg::ST_LONG;
                        end else begin
                            tx_len_we    = 1'b1;
                            tx_len_wd    = v_pos;
                            n_tx_tail    = f_next(r_tx_tail);
                            n_tx_fill    = r_tx_fill + 1'b1;
                            n_out_status = fgpq_pkg::ST_OK;
                        end
                        n_write_pos = '0;
                        n_write_ovf = 1'b0;
                    end
                end
                fgpq_pkg::OP_HOST_READ: begin
                    if (rx_any) begin
                        n_out_kind   = fgpq_pkg::KIND_RX;
                        n_out_bvalid = (rx_head_len != '0);
                        n_out_eor    = (rx_head_len <= LW'(1));
                        n_em_kind    = fgpq_pkg::KIND_RX;
                        n_em_slot    = r_rx_head;
                        n_em_len     = rx_head_len;
                        n_em_idx     = LW'(1);
                        rx_re        = 1'b1;
                        rx_ra        = f_addr(r_rx_head, '0);
                        n_rx_head    = f_next(r_rx_head);
                        n_rx_fill    = r_rx_fill - 1'b1;
                    end else begin
                        n_out_status = fgpq_pkg::ST_EMPTY;
                    end
                end
                default: begin
                    // unused op codes: plain ok status
                end
            endcase
        end else if (i_ctl.emit_next) begin
            n_out_vld    = 1'b1;
            n_out_kind   = r_em_kind;
            n_out_bvalid = 1'b1;
            n_out_eor    = !step_more;
            n_out_status = fgpq_pkg::ST_OK;
            rx_re        = (r_em_kind == fgpq_pkg::KIND_RX);
            tx_re        = (r_em_kind == fgpq_pkg::KIND_TX);
            n_em_idx     = r_em_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_rx_head   <= '0;
            r_rx_tail   <= '0;
            r_rx_fill   <= '0;
            r_frame_len <= '0;
            r_frame_ovf <= 1'b0;
            r_tx_head   <= '0;
            r_tx_tail   <= '0;
            r_tx_fill   <= '0;
            r_write_pos <= '0;
            r_write_ovf <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_rx_head   <= n_rx_head;
            r_rx_tail   <= n_rx_tail;
            r_rx_fill   <= n_rx_fill;
            r_frame_len <= n_frame_len;
            r_frame_ovf <= n_frame_ovf;
            r_tx_head   <= n_tx_head;
            r_tx_tail   <= n_tx_tail;
            r_tx_fill   <= n_tx_fill;
            r_write_pos <= n_write_pos;
            r_write_ovf <= n_write_ovf;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_em_kind    <= n_em_kind;
        r_em_slot    <= n_em_slot;
        r_em_len     <= n_em_len;
        r_em_idx     <= n_em_idx;
        r_out_kind   <= n_out_kind;
        r_out_bvalid <= n_out_bvalid;
        r_out_eor    <= n_out_eor;
        r_out_status <= n_out_status;
        if (rx_len_we) begin
            r_rx_len[r_rx_tail] <= r_frame_len;
        end
        if (tx_len_we) begin
            r_tx_len[r_tx_tail] <= tx_len_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            r_rx_mem[rx_wa] <= i_req.data;
        end
        if (rx_re) begin
            r_rx_rd <= r_rx_mem[rx_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tx_we) begin
            r_tx_mem[tx_wa] <= i_req.data;
        end
        if (tx_re) begin
            r_tx_rd <= r_tx_mem[tx_ra];
        end
    end

    assign rx_cnt_ext = (FW + 3)'(r_rx_fill);
    assign tx_cnt_ext = (FW + 3)'(r_tx_fill);

    assign o_strobe         = r_out_vld;
    assign o_res.kind       = r_out_kind;
    assign o_res.byte_out   = !r_out_bvalid ? 8'd0 :
                              (r_out_kind == fgpq_pkg::KIND_TX) ? r_tx_rd : r_rx_rd;
    assign o_res.byte_valid = r_out_bvalid;
    assign o_res.end_of_run = r_out_eor;
    assign o_res.status     = r_out_status;
    assign o_res.bus_active = r_active;
    assign o_res.rx_count   = rx_cnt_ext[2:0];
    assign o_res.tx_count   = tx_cnt_ext[2:0];

`ifndef NO_ASSERTIONS
    a_accept_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.accept |=> r_out_vld)
        else $error("request accepted without a result");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_eor) |=> (r_out_vld && (r_out_kind == $past(r_out_kind))))
        else $error("packet run broke off before its last byte");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rx_fill <= FULL_FILL) && (r_tx_fill <= FULL_FILL))
        else $error("queue fill beyond depth");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.accept && i_ctl.emit_next))
        else $error("accept during packet emission");
`endif

endmodule

/* rtl/frame_gated_packet_queues.sv */
`timescale 1ns / 1ps

// Two packet queues, transmit and receive, gated by frame start and frame end requests.
// A request is taken when start is high and busy is low. Every request gives at least one
// result on o_res, each shown for exactly one cycle with o_strobe high; the receiver
// cannot stall, so it must take every strobed result. Status-only requests (frame end,
// line byte, host write byte, empty queue, unused codes) give one result in the cycle
// after acceptance and leave busy low. Frame start and host read emit a stored packet of
// L bytes as max(1, L) results on consecutive cycles starting the cycle after acceptance;
// busy stays high while later bytes are read, paced by the single read port of the packet
// store, one byte per cycle. The next request may be taken in the cycle of the last result.
// Store contents need no clearing after reset.
module frame_gated_packet_queues #(
    parameter int QUEUE_DEPTH = fgpq_pkg::QUEUE_DEPTH,
    parameter int FRAME_BYTES = fgpq_pkg::FRAME_BYTES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  fgpq_pkg::t_req  i_req,
    output logic            o_strobe,
    output fgpq_pkg::t_res  o_res
);

    fgpq_pkg::t_ctl ctl;
    fgpq_pkg::t_sts sts;

    fgpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_ctl   (ctl),
        .i_sts   (sts)
    );

    fgpq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

endmodule

/* sim/frame_gated_packet_queues_tb.sv */
`timescale 1ns / 1ps

module frame_gated_packet_queues_tb;

    localparam int STORE_BYTES = fgpq_pkg::QUEUE_DEPTH * fgpq_pkg::FRAME_BYTES;
    localparam int STORE_AW    = $clog2(STORE_BYTES);
    localparam int RANDOM_REQS = 16;
    localparam int TAIL_CYCLES = 2 * fgpq_pkg::FRAME_BYTES + 8;

    // op codes the block ignores
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef struct {
        fgpq_pkg::t_req req;
        int             reps;
        bit             typed;
        fgpq_pkg::t_res want;
    } t_step;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    fgpq_pkg::t_req i_req;
    logic           o_strobe;
    fgpq_pkg::t_res o_res;

    frame_gated_packet_queues dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // shadow copy of both packet queues
    logic [7:0] rx_bytes [STORE_BYTES];
    logic [5:0] rx_sizes [fgpq_pkg::QUEUE_DEPTH];
    logic [1:0] rx_rd, rx_wr;
    logic [2:0] rx_used;
    logic [5:0] line_len;
    logic       line_bad;
    logic [7:0] tx_bytes [STORE_BYTES];
    logic [5:0] tx_sizes [fgpq_pkg::QUEUE_DEPTH];
    logic [1:0] tx_rd, tx_wr;
    logic [2:0] tx_used;
    logic [5:0] host_pos;
    logic       host_bad;
    logic       bus_on;

    fgpq_pkg::t_res fresh[$];     // results of the request just taken
    fgpq_pkg::t_res awaited[$];   // results still to come from the block
    fgpq_pkg::t_res got_res;
    t_step          plan[$];

    int errors = 0;
    int req_count = 0;
    int live_reqs = 0;
    int results_seen = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    bit no_idle = 1'b0;

    function automatic logic [STORE_AW-1:0] byte_at(logic [1:0] slot, int pos);
        return STORE_AW'(int'(slot) * fgpq_pkg::FRAME_BYTES + pos);
    endfunction

    function automatic fgpq_pkg::t_req req_of(logic [2:0] op, logic [7:0] data, logic last);
        fgpq_pkg::t_req r;
        r.op   = op;
        r.data = data;
        r.last = last;
        return r;
    endfunction

    function automatic t_step plain(logic [2:0] op, logic [7:0] data, logic last, int reps);
        t_step s;
        s.req   = req_of(op, data, last);
        s.reps  = reps;
        s.typed = 1'b0;
        s.want  = '0;
        return s;
    endfunction

    // single-result request whose outcome is obvious; byte_out is always 0 here
    function automatic t_step checked(logic [2:0] op, logic [7:0] data, logic last,
                                      logic [1:0] kind, logic valid, logic [1:0] st,
                                      logic bus, logic [2:0] rx, logic [2:0] tx);
        t_step s;
        s.req   = req_of(op, data, last);
        s.reps  = 1;
        s.typed = 1'b1;
        s.want  = '0;
        s.want.kind       = kind;
        s.want.byte_valid = valid;
        s.want.end_of_run = 1'b1;
        s.want.status     = st;
        s.want.bus_active = bus;
        s.want.rx_count   = rx;
        s.want.tx_count   = tx;
        return s;
    endfunction

    function automatic void push_status(logic [1:0] st);
        fgpq_pkg::t_res r;
        r        = '0;
        r.kind   = fgpq_pkg::KIND_STATUS;
        r.status = st;
        fresh.push_back(r);
    endfunction

    function automatic void emit_packet(logic [1:0] kind, bit from_tx, logic [1:0] slot,
                                        logic [5:0] len);
        fgpq_pkg::t_res r;
        int             i;
        if (len == 0) begin
            r      = '0;
            r.kind = kind;
            fresh.push_back(r);
        end else begin
            for (i = 0; i < int'(len); i++) begin
                r            = '0;
                r.kind       = kind;
                r.byte_valid = 1'b1;
                r.byte_out   = from_tx ? tx_bytes[byte_at(slot, i)]
                                       : rx_bytes[byte_at(slot, i)];
                fresh.push_back(r);
            end
        end
    endfunction

    function automatic void reset_queues();
        rx_rd    = '0;
        rx_wr    = '0;
        rx_used  = '0;
        line_len = '0;
        line_bad = 1'b0;
        tx_rd    = '0;
        tx_wr    = '0;
        tx_used  = '0;
        host_pos = '0;
        host_bad = 1'b0;
        bus_on   = 1'b0;
    endfunction

    // advance the shadow queues by one request and fill fresh with its results
    function automatic void apply_request(fgpq_pkg::t_req r);
        logic [1:0] st;
        int         k;
        fresh.delete();
        st = fgpq_pkg::ST_OK;
        case (r.op)
            fgpq_pkg::OP_FRAME_START: begin
                bus_on   = 1'b1;
                line_len = '0;
                line_bad = 1'b0;
                if (tx_used != 0) begin
                    emit_packet(fgpq_pkg::KIND_TX, 1'b1, tx_rd, tx_sizes[tx_rd]);
                    tx_rd++;
                    tx_used--;
                end else begin
                    push_status(fgpq_pkg::ST_EMPTY);
                end
            end
            fgpq_pkg::OP_FRAME_END: begin
                bus_on = 1'b0;
                if (rx_used >= fgpq_pkg::QUEUE_DEPTH) begin
                    st = fgpq_pkg::ST_FULL;
                end else if (line_bad) begin
                    st = fgpq_pkg::ST_LONG;
                end else begin
                    rx_sizes[rx_wr] = line_len;
                    rx_wr++;
                    rx_used++;
                end
                line_len = '0;
                line_bad = 1'b0;
                push_status(st);
            end
            fgpq_pkg::OP_LINE_BYTE: begin
                if (rx_used >= fgpq_pkg::QUEUE_DEPTH) begin
                    line_bad = 1'b1;
                    st = fgpq_pkg::ST_FULL;
                end else if (line_len >= fgpq_pkg::FRAME_BYTES) begin
                    line_bad = 1'b1;
                    st = fgpq_pkg::ST_LONG;
                end else begin
                    rx_bytes[byte_at(rx_wr, int'(line_len))] = r.data;
                    line_len++;
                end
                push_status(st);
            end
            fgpq_pkg::OP_HOST_WRITE: begin
                if (tx_used >= fgpq_pkg::QUEUE_DEPTH) begin
                    host_bad = 1'b1;
                    st = fgpq_pkg::ST_FULL;
                end else if (host_pos >= fgpq_pkg::FRAME_BYTES) begin
                    host_bad = 1'b1;
                    st = fgpq_pkg::ST_LONG;
                end else begin
                    tx_bytes[byte_at(tx_wr, int'(host_pos))] = r.data;
                    host_pos++;
                end
                if (r.last) begin
                    if (tx_used >= fgpq_pkg::QUEUE_DEPTH) begin
                        st = fgpq_pkg::ST_FULL;
                    end else if (host_bad) begin
                        st = fgpq_pkg::ST_LONG;
                    end else begin
                        tx_sizes[tx_wr] = host_pos;
                        tx_wr++;
                        tx_used++;
                        st = fgpq_pkg::ST_OK;
                    end
                    host_pos = '0;
                    host_bad = 1'b0;
                end
                push_status(st);
            end
            fgpq_pkg::OP_HOST_READ: begin
                if (rx_used != 0) begin
                    emit_packet(fgpq_pkg::KIND_RX, 1'b0, rx_rd, rx_sizes[rx_rd]);
                    rx_rd++;
                    rx_used--;
                end else begin
                    push_status(fgpq_pkg::ST_EMPTY);
                end
            end
            default: push_status(fgpq_pkg::ST_OK);
        endcase
        for (k = 0; k < fresh.size(); k++) begin
            fresh[k].end_of_run = (k == fresh.size() - 1);
            fresh[k].bus_active = bus_on;
            fresh[k].rx_count   = rx_used;
            fresh[k].tx_count   = tx_used;
        end
    endfunction

    // hold the request until taken, then idle for a random number of cycles
    task automatic issue(input fgpq_pkg::t_req r, input bit typed, input fgpq_pkg::t_res want);
        int gap;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        apply_request(r);
        if (typed)
            awaited.push_back(want);
        else
            foreach (fresh[k]) awaited.push_back(fresh[k]);
        req_count++;
        if (r.op <= fgpq_pkg::OP_HOST_READ)
            live_reqs++;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send(input logic [2:0] op, input logic [7:0] data, input logic last);
        issue(req_of(op, data, last), 1'b0, '0);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: result %0d %s mismatch, expected %0h actual %0h",
                     $time, results_seen, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            results_seen++;
            status_seen[o_res.status]++;
            if (awaited.size() == 0) begin
                $display("%0t ns: result with nothing expected, expected none actual %p",
                         $time, o_res);
                errors++;
            end else begin
                got_res = awaited.pop_front();
                check_field("kind", int'(got_res.kind), int'(o_res.kind));
                check_field("byte_out", int'(got_res.byte_out), int'(o_res.byte_out));
                check_field("byte_valid", int'(got_res.byte_valid), int'(o_res.byte_valid));
                check_field("end_of_run", int'(got_res.end_of_run), int'(o_res.end_of_run));
                check_field("status", int'(got_res.status), int'(o_res.status));
                check_field("bus_active", int'(got_res.bus_active), int'(o_res.bus_active));
                check_field("rx_count", int'(got_res.rx_count), int'(o_res.rx_count));
                check_field("tx_count", int'(got_res.tx_count), int'(o_res.tx_count));
            end
        end
    end

    initial begin
        #500000;
        $display("frame_gated_packet_queues test failed");
        $finish;
    end

    initial begin
        int             seq;
        int             len;
        int             j;
        int             wait_cycles;
        int             base_live;
        fgpq_pkg::t_req r;
        t_step          s;

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        reset_queues();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        plan.push_back(checked(OP_SPARE_5, 8'h00, 1'b0, fgpq_pkg::KIND_STATUS, 1'b0,
                               fgpq_pkg::ST_OK, 1'b0, 3'd0, 3'd0));
        plan.push_back(checked(fgpq_pkg::OP_FRAME_START, 8'h00, 1'b0, fgpq_pkg::KIND_STATUS,
                               1'b0, fgpq_pkg::ST_EMPTY, 1'b1, 3'd0, 3'd0));
        plan.push_back(checked(fgpq_pkg::OP_HOST_READ, 8'h00, 1'b0, fgpq_pkg::KIND_STATUS,
                               1'b0, fgpq_pkg::ST_EMPTY, 1'b1, 3'd0, 3'd0));
        plan.push_back(checked(OP_SPARE_7, 8'hFF, 1'b1, fgpq_pkg::KIND_STATUS, 1'b0,
                               fgpq_pkg::ST_OK, 1'b1, 3'd0, 3'd0));
        // empty frame is committed and read back as one byteless result
        plan.push_back(checked(fgpq_pkg::OP_FRAME_END, 8'h00, 1'b0, fgpq_pkg::KIND_STATUS,
                               1'b0, fgpq_pkg::ST_OK, 1'b0, 3'd1, 3'd0));
        plan.push_back(checked(fgpq_pkg::OP_HOST_READ, 8'h00, 1'b0, fgpq_pkg::KIND_RX,
                               1'b0, fgpq_pkg::ST_OK, 1'b0, 3'd0, 3'd0));
        // line bytes with the bus inactive still land in the frame
        plan.push_back(checked(fgpq_pkg::OP_LINE_BYTE, 8'h00, 1'b0, fgpq_pkg::KIND_STATUS,
                               1'b0, fgpq_pkg::ST_OK, 1'b0, 3'd0, 3'd0));
        plan.push_back(plain(fgpq_pkg::OP_LINE_BYTE, 8'hFF, 1'b1, 1));
        plan.push_back(checked(fgpq_pkg::OP_FRAME_END, 8'h00, 1'b0, fgpq_pkg::KIND_STATUS,
                               1'b0, fgpq_pkg::ST_OK, 1'b0, 3'd1, 3'd0));
        plan.push_back(plain(fgpq_pkg::OP_HOST_READ, 8'h00, 1'b0, 1));
        plan.push_back(checked(fgpq_pkg::OP_HOST_WRITE, 8'h00, 1'b0, fgpq_pkg::KIND_STATUS,
                               1'b0, fgpq_pkg::ST_OK, 1'b0, 3'd0, 3'd0));
        plan.push_back(checked(fgpq_pkg::OP_HOST_WRITE, 8'hFF, 1'b1, fgpq_pkg::KIND_STATUS,
                               1'b0, fgpq_pkg::ST_OK, 1'b0, 3'd0, 3'd1));
        plan.push_back(plain(fgpq_pkg::OP_FRAME_START, 8'h00, 1'b0, 1));
        // fill the receive queue, then overrun it
        plan.push_back(plain(fgpq_pkg::OP_FRAME_END, 8'h00, 1'b0, 4));
        plan.push_back(checked(fgpq_pkg::OP_LINE_BYTE, 8'h3C, 1'b0, fgpq_pkg::KIND_STATUS,
                               1'b0, fgpq_pkg::ST_FULL, 1'b0, 3'd4, 3'd0));
        plan.push_back(checked(fgpq_pkg::OP_FRAME_END, 8'h00, 1'b0, fgpq_pkg::KIND_STATUS,
                               1'b0, fgpq_pkg::ST_FULL, 1'b0, 3'd4, 3'd0));
        // fill the transmit queue, then overrun it
        plan.push_back(plain(fgpq_pkg::OP_HOST_WRITE, 8'h10, 1'b1, 4));
        plan.push_back(checked(fgpq_pkg::OP_HOST_WRITE, 8'h77, 1'b0, fgpq_pkg::KIND_STATUS,
                               1'b0, fgpq_pkg::ST_FULL, 1'b0, 3'd4, 3'd4));
        plan.push_back(checked(fgpq_pkg::OP_HOST_WRITE, 8'h88, 1'b1, fgpq_pkg::KIND_STATUS,
                               1'b0, fgpq_pkg::ST_FULL, 1'b0, 3'd4, 3'd4));
        plan.push_back(plain(fgpq_pkg::OP_HOST_READ, 8'h00, 1'b0, 4));
        // one byte past the frame limit
        plan.push_back(plain(fgpq_pkg::OP_LINE_BYTE, 8'h40, 1'b0, fgpq_pkg::FRAME_BYTES + 1));
        plan.push_back(checked(fgpq_pkg::OP_FRAME_END, 8'h00, 1'b0, fgpq_pkg::KIND_STATUS,
                               1'b0, fgpq_pkg::ST_LONG, 1'b0, 3'd0, 3'd4));
        plan.push_back(plain(fgpq_pkg::OP_FRAME_START, 8'h00, 1'b0, 4));
        // final host byte lands one past the limit
        plan.push_back(plain(fgpq_pkg::OP_HOST_WRITE, 8'h80, 1'b0, fgpq_pkg::FRAME_BYTES));
        plan.push_back(checked(fgpq_pkg::OP_HOST_WRITE, 8'h99, 1'b1, fgpq_pkg::KIND_STATUS,
                               1'b0, fgpq_pkg::ST_LONG, 1'b1, 3'd0, 3'd0));
        // largest packet that fits, sent as the longest run
        plan.push_back(plain(fgpq_pkg::OP_HOST_WRITE, 8'hE0, 1'b0, fgpq_pkg::FRAME_BYTES - 1));
        plan.push_back(plain(fgpq_pkg::OP_HOST_WRITE, 8'h1F, 1'b1, 1));
        plan.push_back(plain(fgpq_pkg::OP_FRAME_START, 8'h00, 1'b0, 1));

        foreach (plan[i]) begin
            s = plan[i];
            for (j = 0; j < s.reps; j++) begin
                r      = s.req;
                r.data = s.req.data + 8'(j);
                issue(r, s.typed, s.want);
            end
        end

        base_live = live_reqs;
        while (live_reqs < base_live + RANDOM_REQS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            seq     = $urandom_range(0, 9);
            len     = $urandom_range(0, 6);
            if (seq <= 2) begin
                if ($urandom_range(0, 3) != 0)
                    send(fgpq_pkg::OP_FRAME_START, 8'($urandom), 1'($urandom));
                for (j = 0; j < len; j++)
                    send(fgpq_pkg::OP_LINE_BYTE, 8'($urandom), 1'($urandom));
                if ($urandom_range(0, 7) != 0)
                    send(fgpq_pkg::OP_FRAME_END, 8'($urandom), 1'($urandom));
            end else if (seq <= 5) begin
                // a packet dropped short of its final byte runs into the next one
                for (j = 0; j <= len; j++)
                    send(fgpq_pkg::OP_HOST_WRITE, 8'($urandom),
                         (j == len) && ($urandom_range(0, 7) != 0));
            end else if (seq <= 7) begin
                send(fgpq_pkg::OP_HOST_READ, 8'($urandom), 1'($urandom));
            end else if (seq == 8) begin
                send(fgpq_pkg::OP_FRAME_START, 8'($urandom), 1'($urandom));
            end else begin
                for (j = 0; j < $urandom_range(1, 4); j++)
                    send(3'($urandom), 8'($urandom), 1'($urandom));
            end
        end

        start <= 1'b0;
        wait_cycles = 0;
        while (awaited.size() != 0 && wait_cycles < 1000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (awaited.size() != 0) begin
            $display("%0t ns: %0d expected results never arrived, expected %p actual none",
                     $time, awaited.size(), awaited[0]);
            errors++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests (%0d with live op codes), %0d results checked.",
                 req_count, live_reqs, results_seen);
        $display("Status mix: %0d ok, %0d full, %0d empty, %0d too long; %0d mismatches.",
                 status_seen[fgpq_pkg::ST_OK], status_seen[fgpq_pkg::ST_FULL],
                 status_seen[fgpq_pkg::ST_EMPTY], status_seen[fgpq_pkg::ST_LONG], errors);
        if (errors == 0)
            $display("frame_gated_packet_queues test passed");
        else
            $display("frame_gated_packet_queues test failed");
        $finish;
    end

endmodule
